@@ hdl/voxel_dose_tally_defines.svh @@
// ----------------------------------------------------------------------------
// Voxel dose tally assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VOXEL_DOSE_TALLY_DEFINES_SVH
`define VOXEL_DOSE_TALLY_DEFINES_SVH

`ifndef SYNTHESIS
`define VDT_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voxel dose tally assertion failed");
`define VDT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voxel dose tally assertion failed");
`else
`define VDT_ASSERT_SAME(name, clk, rst, ante, cons)
`define VDT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ hdl/vdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel dose tally package
// Shared types, codes and constants of the tally controller and datapath.
// ----------------------------------------------------------------------------
package vdt_pkg;

   localparam int MAX_VOXELS_DEFAULT = 32;

   localparam logic OP_DEPOSIT = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_OUTSIDE      = 3'd1;
   localparam logic [2:0] ST_ZERO_DEPOSIT = 3'd2;
   localparam logic [2:0] ST_RANGE        = 3'd3;
   localparam logic [2:0] ST_ZERO_DENSITY = 3'd4;

   localparam logic [1:0] REG_AXIS_X = 2'd0;
   localparam logic [1:0] REG_AXIS_Y = 2'd1;
   localparam logic [1:0] REG_AXIS_Z = 2'd2;
   localparam logic [1:0] REG_VOLUME = 2'd3;

   localparam logic [5:0]  AXIS_RESET   = 6'd32;
   localparam logic [31:0] VOLUME_RESET = 32'd1048576;
   localparam logic [31:0] DEV_SCALE    = 32'd655360000;

   localparam logic [1:0] MUL_NQ  = 2'd0;
   localparam logic [1:0] MUL_S2  = 2'd1;
   localparam logic [1:0] MUL_NUM = 2'd2;
   localparam logic [1:0] MUL_DEN = 2'd3;

   localparam logic DIV_SRC_DOSE = 1'b0;
   localparam logic DIV_SRC_DEV  = 1'b1;

   localparam logic [1:0] DEV_ZERO = 2'd0;
   localparam logic [1:0] DEV_SAT  = 2'd1;
   localparam logic [1:0] DEV_ROOT = 2'd2;

   localparam logic [6:0] DIV_LAST        = 7'd127;
   localparam logic [6:0] SQRT_LAST       = 7'd15;
   localparam logic [6:0] MUL_NARROW_LAST = 7'd31;
   localparam logic [6:0] MUL_WIDE_LAST   = 7'd47;

   typedef struct packed {
      logic [31:0] hits;
      logic [47:0] sum;
      logic [63:0] sq;
      logic [15:0] dev;
   } rec_type;

   typedef struct packed {
      logic       capture;
      logic       clear;
      logic       load_rec;
      logic       mass;
      logic       div_load;
      logic       div_src;
      logic       div_step;
      logic       dose;
      logic       accum;
      logic       mul_load;
      logic [1:0] mul_sel;
      logic       mul_step;
      logic       mul_store;
      logic       diff;
      logic       sqrt_load;
      logic       sqrt_step;
      logic       dev_set;
      logic [1:0] dev_src;
      logic       write;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic early;
      logic hits_ge2;
      logic sum_zero;
      logic diff_neg;
      logic quo_ovf;
   } stat_type;

endpackage
`default_nettype wire

@@ hdl/vdt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel dose tally controller
// Sequences the clearing pass, the dose division, the deviation chain and
// the result strobe.
// ----------------------------------------------------------------------------
`include "voxel_dose_tally_defines.svh"
module vdt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  vdt_pkg::stat_type stat,
   output vdt_pkg::cmd_type  cmd
);
   import vdt_pkg::*;

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_LOOKUP  = 5'd2;
   localparam logic [4:0] S_CHECK   = 5'd3;
   localparam logic [4:0] S_MASS    = 5'd4;
   localparam logic [4:0] S_DDIV_LD = 5'd5;
   localparam logic [4:0] S_DDIV    = 5'd6;
   localparam logic [4:0] S_DOSE    = 5'd7;
   localparam logic [4:0] S_ACCUM   = 5'd8;
   localparam logic [4:0] S_DEVCHK  = 5'd9;
   localparam logic [4:0] S_MUL_LD  = 5'd10;
   localparam logic [4:0] S_MUL     = 5'd11;
   localparam logic [4:0] S_MUL_ST  = 5'd12;
   localparam logic [4:0] S_DIFF    = 5'd13;
   localparam logic [4:0] S_QDIV_LD = 5'd14;
   localparam logic [4:0] S_QDIV    = 5'd15;
   localparam logic [4:0] S_SQ_LD   = 5'd16;
   localparam logic [4:0] S_SQ      = 5'd17;
   localparam logic [4:0] S_SQ_ST   = 5'd18;
   localparam logic [4:0] S_WRITE   = 5'd19;
   localparam logic [4:0] S_RESPOND = 5'd20;

   logic [4:0] state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic [6:0] mul_last;

   assign mul_last  = (sel_ff == MUL_S2) ? MUL_WIDE_LAST : MUL_NARROW_LAST;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESPOND);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      sel_in      = sel_ff;
      cmd         = '0;
      cmd.mul_sel = sel_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: state_in = S_CHECK;
         S_CHECK: begin
            cmd.load_rec = 1'b1;
            state_in     = stat.early ? S_RESPOND : S_MASS;
         end
         S_MASS: begin
            cmd.mass = 1'b1;
            state_in = S_DDIV_LD;
         end
         S_DDIV_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_src  = DIV_SRC_DOSE;
            cnt_in       = '0;
            state_in     = S_DDIV;
         end
         S_DDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) state_in = S_DOSE;
         end
         S_DOSE: begin
            cmd.dose = 1'b1;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = S_DEVCHK;
         end
         S_DEVCHK: begin
            if (!stat.hits_ge2) begin
               state_in = S_WRITE;
            end else if (stat.sum_zero) begin
               cmd.dev_set = 1'b1;
               cmd.dev_src = DEV_ZERO;
               state_in    = S_WRITE;
            end else begin
               sel_in   = MUL_NQ;
               state_in = S_MUL_LD;
            end
         end
         S_MUL_LD: begin
            cmd.mul_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 7'd1;
            if (cnt_ff == mul_last) state_in = S_MUL_ST;
         end
         S_MUL_ST: begin
            cmd.mul_store = 1'b1;
            case (sel_ff)
               MUL_NQ: begin
                  sel_in   = MUL_S2;
                  state_in = S_MUL_LD;
               end
               MUL_S2:  state_in = S_DIFF;
               MUL_NUM: begin
                  sel_in   = MUL_DEN;
                  state_in = S_MUL_LD;
               end
               default: state_in = S_QDIV_LD;
            endcase
         end
         S_DIFF: begin
            if (stat.diff_neg) begin
               cmd.dev_set = 1'b1;
               cmd.dev_src = DEV_ZERO;
               state_in    = S_WRITE;
            end else begin
               cmd.diff = 1'b1;
               sel_in   = MUL_NUM;
               state_in = S_MUL_LD;
            end
         end
         S_QDIV_LD: begin
            cmd.div_load = 1'b1;
            cmd.div_src  = DIV_SRC_DEV;
            cnt_in       = '0;
            state_in     = S_QDIV;
         end
         S_QDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) state_in = S_SQ_LD;
         end
         S_SQ_LD: begin
            if (stat.quo_ovf) begin
               cmd.dev_set = 1'b1;
               cmd.dev_src = DEV_SAT;
               state_in    = S_WRITE;
            end else begin
               cmd.sqrt_load = 1'b1;
               cnt_in        = '0;
               state_in      = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 7'd1;
            if (cnt_ff == SQRT_LAST) state_in = S_SQ_ST;
         end
         S_SQ_ST: begin
            cmd.dev_set = 1'b1;
            cmd.dev_src = DEV_ROOT;
            state_in    = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_RESPOND;
         end
         S_RESPOND: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         sel_ff   <= MUL_NQ;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   `VDT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `VDT_ASSERT_NEXT(a_accept_lookup, clock, reset, start && !busy, state_ff == S_LOOKUP)
   `VDT_ASSERT_NEXT(a_write_respond, clock, reset, cmd.write, rsp_valid)
   `VDT_ASSERT_SAME(a_clear_no_write, clock, reset, cmd.clear, !cmd.write && busy)

endmodule
`default_nettype wire

@@ hdl/vdt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel dose tally datapath
// Voxel record memory, configuration registers, shift-add multiplier,
// restoring divider and bit-pair square root.
// ----------------------------------------------------------------------------
module vdt_datapath #(
   parameter int MAX_VOXELS_PER_AXIS = vdt_pkg::MAX_VOXELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_opcode,
   input  logic              req_in_scoring_volume,
   input  logic [31:0]       req_energy_deposit,
   input  logic [15:0]       req_material_density,
   input  logic [4:0]        req_index_x,
   input  logic [4:0]        req_index_y,
   input  logic [4:0]        req_index_z,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output logic [2:0]        rsp_status,
   output logic [31:0]       rsp_hit_count,
   output logic [47:0]       rsp_dose_total,
   output logic [63:0]       rsp_dose_square_total,
   output logic [15:0]       rsp_relative_deviation,
   output logic [31:0]       rsp_total_hits,
   input  vdt_pkg::cmd_type  cmd,
   output vdt_pkg::stat_type stat
);
   import vdt_pkg::*;

   localparam int DEPTH  = MAX_VOXELS_PER_AXIS * MAX_VOXELS_PER_AXIS * MAX_VOXELS_PER_AXIS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [9:0] MAX_LIM = 10'(MAX_VOXELS_PER_AXIS);
   localparam logic [ADDR_W-1:0] MAX_A = ADDR_W'(MAX_VOXELS_PER_AXIS);
   localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

   logic [5:0]  axis_x_ff, axis_y_ff, axis_z_ff;
   logic [31:0] volume_ff;
   logic [31:0] total_ff;
   logic [ADDR_W-1:0] clr_ff;

   logic              op_ff;
   logic [2:0]        status_ff;
   logic [31:0]       energy_ff;
   logic [15:0]       density_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [47:0]       mass_ff;
   logic [47:0]       dose_ff;
   logic [63:0]       dsq_ff;

   rec_type mem [DEPTH];
   rec_type rd_ff, rec_ff;

   logic [127:0] dvd_ff, dvs_ff;
   logic [128:0] rem_ff;
   logic [127:0] a_ff, acc_ff, nq_ff, s2_ff, num_ff, den_ff;
   logic [47:0]  b_ff;
   logic [31:0]  sv_ff, sres_ff, sbit_ff;

   logic              in_range;
   logic [2:0]        status_in;
   logic [ADDR_W-1:0] addr_in;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   rec_type           wr_data;
   logic [128:0]      rem_sh;
   logic              div_ge;
   logic [47:0]       dose_sat;
   logic [63:0]       dsq_full;
   logic [48:0]       sum_ext;
   logic [64:0]       sq_ext;
   logic [31:0]       sq_trial;
   logic              rsp_ok;

   assign in_range = (10'(req_index_x) < 10'(axis_x_ff)) && (10'(req_index_x) < MAX_LIM)
                  && (10'(req_index_y) < 10'(axis_y_ff)) && (10'(req_index_y) < MAX_LIM)
                  && (10'(req_index_z) < 10'(axis_z_ff)) && (10'(req_index_z) < MAX_LIM);

   assign addr_in = (ADDR_W'(req_index_x) * MAX_A + ADDR_W'(req_index_y)) * MAX_A
                  + ADDR_W'(req_index_z);

   always_comb begin
      if (req_opcode == OP_READ) begin
         status_in = in_range ? ST_OK : ST_RANGE;
      end else if (!req_in_scoring_volume) begin
         status_in = ST_OUTSIDE;
      end else if (req_energy_deposit == 32'd0) begin
         status_in = ST_ZERO_DEPOSIT;
      end else if (!in_range) begin
         status_in = ST_RANGE;
      end else if (req_material_density == 16'd0 || volume_ff == 32'd0) begin
         status_in = ST_ZERO_DENSITY;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= AXIS_RESET;
         axis_y_ff <= AXIS_RESET;
         axis_z_ff <= AXIS_RESET;
         volume_ff <= VOLUME_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_AXIS_X: axis_x_ff <= csr_wdata[5:0];
            REG_AXIS_Y: axis_y_ff <= csr_wdata[5:0];
            REG_AXIS_Z: axis_z_ff <= csr_wdata[5:0];
            REG_VOLUME: volume_ff <= csr_wdata;
            default:    volume_ff <= volume_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.clear) clr_ff <= (clr_ff == LAST_A) ? '0 : clr_ff + ADDR_W'(1);
         if (cmd.accum && total_ff != 32'hFFFF_FFFF) total_ff <= total_ff + 32'd1;
      end
   end

   assign wr_en   = cmd.clear || cmd.write;
   assign wr_addr = cmd.clear ? clr_ff : addr_ff;
   assign wr_data = cmd.clear ? '0 : rec_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_opcode;
         status_ff  <= status_in;
         energy_ff  <= req_energy_deposit;
         density_ff <= req_material_density;
         addr_ff    <= addr_in;
      end
      if (cmd.mass) mass_ff <= 48'(volume_ff) * 48'(density_ff);
   end

   assign rem_sh = {rem_ff[127:0], dvd_ff[127]};
   assign div_ge = (rem_sh >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         if (cmd.div_src == DIV_SRC_DOSE) begin
            dvd_ff <= {68'd0, energy_ff, 28'd0};
            dvs_ff <= {80'd0, mass_ff};
         end else begin
            dvd_ff <= num_ff;
            dvs_ff <= den_ff;
         end
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         dvd_ff <= {dvd_ff[126:0], div_ge};
      end
   end

   assign dose_sat = (|dvd_ff[127:48]) ? 48'hFFFF_FFFF_FFFF : dvd_ff[47:0];
   assign dsq_full = {32'd0, dose_sat[31:0]} * {32'd0, dose_sat[31:0]};

   always_ff @(posedge clock) begin
      if (cmd.dose) begin
         dose_ff <= dose_sat;
         dsq_ff  <= (|dose_sat[47:32]) ? 64'hFFFF_FFFF_FFFF_FFFF : dsq_full;
      end
   end

   assign sum_ext = {1'b0, rec_ff.sum} + {1'b0, dose_ff};
   assign sq_ext  = {1'b0, rec_ff.sq} + {1'b0, dsq_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_rec) begin
         rec_ff <= rd_ff;
      end else if (cmd.accum) begin
         rec_ff.sum <= sum_ext[48] ? 48'hFFFF_FFFF_FFFF : sum_ext[47:0];
         rec_ff.sq  <= sq_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_ext[63:0];
         if (rec_ff.hits != 32'hFFFF_FFFF) rec_ff.hits <= rec_ff.hits + 32'd1;
      end else if (cmd.dev_set) begin
         case (cmd.dev_src)
            DEV_ZERO: rec_ff.dev <= 16'd0;
            DEV_SAT:  rec_ff.dev <= 16'hFFFF;
            DEV_ROOT: rec_ff.dev <= sres_ff[15:0];
            default:  rec_ff.dev <= rec_ff.dev;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         acc_ff <= '0;
         case (cmd.mul_sel)
            MUL_NQ: begin
               a_ff <= {64'd0, rec_ff.sq};
               b_ff <= {16'd0, rec_ff.hits};
            end
            MUL_S2: begin
               a_ff <= {80'd0, rec_ff.sum};
               b_ff <= rec_ff.sum;
            end
            MUL_NUM: begin
               a_ff <= nq_ff;
               b_ff <= {16'd0, DEV_SCALE};
            end
            default: begin
               a_ff <= s2_ff;
               b_ff <= {16'd0, rec_ff.hits - 32'd1};
            end
         endcase
      end else if (cmd.mul_step) begin
         if (b_ff[0]) acc_ff <= acc_ff + a_ff;
         a_ff <= {a_ff[126:0], 1'b0};
         b_ff <= {1'b0, b_ff[47:1]};
      end
      if (cmd.mul_store) begin
         case (cmd.mul_sel)
            MUL_NQ:  nq_ff  <= acc_ff;
            MUL_S2:  s2_ff  <= acc_ff;
            MUL_NUM: num_ff <= acc_ff;
            default: den_ff <= acc_ff;
         endcase
      end else if (cmd.diff) begin
         nq_ff <= nq_ff - s2_ff;
      end
   end

   assign sq_trial = sres_ff + sbit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         sv_ff   <= dvd_ff[31:0];
         sres_ff <= '0;
         sbit_ff <= 32'h4000_0000;
      end else if (cmd.sqrt_step) begin
         if (sv_ff >= sq_trial) begin
            sv_ff   <= sv_ff - sq_trial;
            sres_ff <= {1'b0, sres_ff[31:1]} + sbit_ff;
         end else begin
            sres_ff <= {1'b0, sres_ff[31:1]};
         end
         sbit_ff <= {2'b00, sbit_ff[31:2]};
      end
   end

   assign stat.clear_last = (clr_ff == LAST_A);
   assign stat.early      = (op_ff == OP_READ) || (status_ff != ST_OK);
   assign stat.hits_ge2   = (rec_ff.hits >= 32'd2);
   assign stat.sum_zero   = (rec_ff.sum == 48'd0);
   assign stat.diff_neg   = (nq_ff < s2_ff);
   assign stat.quo_ovf    = |dvd_ff[127:32];

   assign rsp_ok                 = (status_ff == ST_OK);
   assign rsp_status             = status_ff;
   assign rsp_hit_count          = rsp_ok ? rec_ff.hits : 32'd0;
   assign rsp_dose_total         = rsp_ok ? rec_ff.sum : 48'd0;
   assign rsp_dose_square_total  = rsp_ok ? rec_ff.sq : 64'd0;
   assign rsp_relative_deviation = rsp_ok ? rec_ff.dev : 16'd0;
   assign rsp_total_hits         = total_ff;

endmodule
`default_nettype wire

@@ hdl/voxel_dose_tally.sv @@
// Reads and rejected deposits skip the arithmetic; an accepted deposit runs the 128-step
// restoring divider, and a deviation update adds the bit-serial multiplier (up to four
// products) and can use the divider a second time before the result strobe.
// One item at a time: busy drops after the result cycle.
// After reset the record memory is cleared one entry a cycle, all MAX_VOXELS_PER_AXIS^3
// entries, with busy high; configuration writes are accepted throughout.
`default_nettype none
// ----------------------------------------------------------------------------
// Voxel dose tally
// Per-voxel dose, squared dose, hit count and relative deviation tally.
// ----------------------------------------------------------------------------
module voxel_dose_tally #(
   parameter int MAX_VOXELS_PER_AXIS = vdt_pkg::MAX_VOXELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic        req_in_scoring_volume,
   input  logic [31:0] req_energy_deposit,
   input  logic [15:0] req_material_density,
   input  logic [4:0]  req_index_x,
   input  logic [4:0]  req_index_y,
   input  logic [4:0]  req_index_z,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_hit_count,
   output logic [47:0] rsp_dose_total,
   output logic [63:0] rsp_dose_square_total,
   output logic [15:0] rsp_relative_deviation,
   output logic [31:0] rsp_total_hits,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import vdt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   vdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   vdt_datapath #(
      .MAX_VOXELS_PER_AXIS (MAX_VOXELS_PER_AXIS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_opcode             (req_opcode),
      .req_in_scoring_volume  (req_in_scoring_volume),
      .req_energy_deposit     (req_energy_deposit),
      .req_material_density   (req_material_density),
      .req_index_x            (req_index_x),
      .req_index_y            (req_index_y),
      .req_index_z            (req_index_z),
      .csr_write              (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_status             (rsp_status),
      .rsp_hit_count          (rsp_hit_count),
      .rsp_dose_total         (rsp_dose_total),
      .rsp_dose_square_total  (rsp_dose_square_total),
      .rsp_relative_deviation (rsp_relative_deviation),
      .rsp_total_hits         (rsp_total_hits),
      .cmd                    (cmd),
      .stat                   (stat)
   );

endmodule
`default_nettype wire
